[rtl/smcn_pkg.sv]
// ----------------------------------------------------------------------------
// smcn_pkg: shared types and constants of the sensor min/max calibrator
// Command codes, register indexes, beat payloads and controller/datapath links.
// ----------------------------------------------------------------------------
package smcn_pkg;

  localparam int unsigned SAMPLE_BITS      = 10;
  localparam int unsigned CHAN_W           = 3;
  localparam int unsigned VALUE_W          = 16;
  localparam int unsigned MASK_W           = 6;
  localparam int unsigned MASK_EXT_W       = 1 << CHAN_W;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned DEFAULT_CHANNELS = 6;

  // Magnitude of (sample - min) * (upper - lower) fits in this many bits.
  localparam int unsigned MAG_W = SAMPLE_BITS + VALUE_W;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [VALUE_W-1:0] LOWER_RST = 16'sd0;
  localparam logic signed [VALUE_W-1:0] UPPER_RST = 16'sd1023;
  localparam logic [MASK_W-1:0]         MASK_RST  = 6'd7;

  typedef enum logic [1:0] {
    CMD_TRACK     = 2'd0,
    CMD_COMMIT    = 2'd1,
    CMD_ABORT     = 2'd2,
    CMD_NORMALIZE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_LOWER   = 2'd0,
    CFG_OUT_UPPER   = 2'd1,
    CFG_INVERT_MASK = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                   command;
    logic [CHAN_W-1:0]      channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [SAMPLE_BITS-1:0]    run_max;
    logic [SAMPLE_BITS-1:0]    run_min;
    logic                      zero_span;
    logic                      saturated;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic div_start;
    logic fin;
    logic load;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic norm;
    logic div_done;
  } stat_t;

endpackage

[rtl/smcn_div.sv]
// ----------------------------------------------------------------------------
// smcn_div: restoring unsigned divider
// One quotient bit per cycle; done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
module smcn_div #(
  parameter int unsigned DividendW = smcn_pkg::MAG_W,
  parameter int unsigned DivisorW  = smcn_pkg::SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic [DividendW-1:0] quotient_o,
  output logic                 done_o
);

  localparam int unsigned CntW = (DividendW > 1) ? $clog2(DividendW) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(DividendW - 1);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    shifted, diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});
  assign rem_d   = ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
  assign quo_d   = {quo_q[DividendW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[rtl/smcn_dp.sv]
// ----------------------------------------------------------------------------
// smcn_dp: calibrator datapath
// Configuration, per-channel extremes, normalize multiply/divide and result.
// ----------------------------------------------------------------------------
module smcn_dp #(
  parameter int unsigned CHANNELS = smcn_pkg::DEFAULT_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smcn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smcn_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  smcn_pkg::in_t                       in_data_i,
  input  smcn_pkg::ctrl_t                     ctrl_i,
  output smcn_pkg::stat_t                     stat_o,
  output smcn_pkg::out_t                      out_data_o
);

  localparam int unsigned SB   = smcn_pkg::SAMPLE_BITS;
  localparam int unsigned VW   = smcn_pkg::VALUE_W;
  localparam int unsigned MagW = smcn_pkg::MAG_W;
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RngW = VW + 1;
  localparam int unsigned PrdW = SB + 1 + RngW;
  localparam int unsigned ResW = MagW + 2;
  localparam logic signed [ResW-1:0] SatHi = ResW'(32767);
  localparam logic signed [ResW-1:0] SatLo = ResW'(-32768);

  // Configuration registers
  logic signed [VW-1:0]            lower_q, upper_q;
  logic [smcn_pkg::MASK_W-1:0]     mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= smcn_pkg::LOWER_RST;
      upper_q <= smcn_pkg::UPPER_RST;
      mask_q  <= smcn_pkg::MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smcn_pkg::CFG_OUT_LOWER:   lower_q <= cfg_wdata_i;
        smcn_pkg::CFG_OUT_UPPER:   upper_q <= cfg_wdata_i;
        smcn_pkg::CFG_INVERT_MASK: mask_q  <= cfg_wdata_i[smcn_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Item register
  smcn_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      in_q <= in_data_i;
    end
  end

  // Per-channel extremes
  logic [SB-1:0] rmax_q [CHANNELS];
  logic [SB-1:0] rmin_q [CHANNELS];
  logic [SB-1:0] smax_q [CHANNELS];
  logic [SB-1:0] smin_q [CHANNELS];

  logic [IdxW-1:0]                     idx;
  logic                                ok;
  logic [smcn_pkg::MASK_EXT_W-1:0]     mask_ext;
  logic                                inv;
  logic [SB-1:0]                       xc, cur_max, cur_min, new_max, new_min;

  assign idx      = IdxW'(in_q.channel);
  assign ok       = (int'(in_q.channel) < int'(CHANNELS));
  assign mask_ext = smcn_pkg::MASK_EXT_W'(mask_q);
  assign inv      = mask_ext[in_q.channel];
  assign xc       = inv ? (smcn_pkg::SAMPLE_FULL - in_q.sample) : in_q.sample;
  assign cur_max  = rmax_q[idx];
  assign cur_min  = rmin_q[idx];
  assign new_max  = (xc > cur_max) ? xc : cur_max;
  assign new_min  = (xc < cur_min) ? xc : cur_min;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rmax_q[c] <= smcn_pkg::SAMPLE_MID;
        rmin_q[c] <= smcn_pkg::SAMPLE_MID;
        smax_q[c] <= smcn_pkg::SAMPLE_FULL;
        smin_q[c] <= '0;
      end
    end else if (ctrl_i.exec) begin
      unique case (in_q.command)
        smcn_pkg::CMD_TRACK: begin
          if (ok) begin
            rmax_q[idx] <= new_max;
            rmin_q[idx] <= new_min;
          end
        end
        smcn_pkg::CMD_COMMIT: begin
          for (int c = 0; c < CHANNELS; c++) begin
            smax_q[c] <= rmax_q[c];
            smin_q[c] <= rmin_q[c];
            rmax_q[c] <= smcn_pkg::SAMPLE_MID;
            rmin_q[c] <= smcn_pkg::SAMPLE_MID;
          end
        end
        smcn_pkg::CMD_ABORT: begin
          for (int c = 0; c < CHANNELS; c++) begin
            rmax_q[c] <= smcn_pkg::SAMPLE_MID;
            rmin_q[c] <= smcn_pkg::SAMPLE_MID;
          end
        end
        smcn_pkg::CMD_NORMALIZE: begin
        end
      endcase
    end
  end

  // Normalize: multiply, then divide the magnitude by the span
  logic signed [SB:0]      diff;
  logic signed [RngW-1:0]  rng;
  logic signed [PrdW-1:0]  prod_q;
  logic [SB-1:0]           span_q;
  logic                    zero_q;
  logic                    neg_q;
  logic [PrdW-1:0]         prod_abs;
  logic [MagW-1:0]         quo;
  logic                    div_done;

  assign diff = $signed({1'b0, in_q.sample}) - $signed({1'b0, smin_q[idx]});
  assign rng  = RngW'(upper_q) - RngW'(lower_q);
  assign prod_abs = prod_q[PrdW-1] ? (-prod_q) : prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PrdW'(diff) * PrdW'(rng);
      span_q <= smax_q[idx] - smin_q[idx];
      zero_q <= (smax_q[idx] == smin_q[idx]);
    end
    if (ctrl_i.div_start) begin
      neg_q <= prod_q[PrdW-1];
    end
  end

  smcn_div #(
    .DividendW (MagW),
    .DivisorW  (SB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (prod_abs[MagW-1:0]),
    .divisor_i  (span_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // Sign the quotient, add lower, saturate
  logic signed [MagW:0]   qs;
  logic signed [ResW-1:0] sum;
  smcn_pkg::out_t         exec_res, norm_res, res_q, out_q;

  assign qs  = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum = ResW'(qs) + ResW'(lower_q);

  always_comb begin
    norm_res         = '0;
    norm_res.run_max = cur_max;
    norm_res.run_min = cur_min;
    if (zero_q) begin
      norm_res.value     = lower_q;
      norm_res.zero_span = 1'b1;
    end else if (sum > SatHi) begin
      norm_res.value     = SatHi[VW-1:0];
      norm_res.saturated = 1'b1;
    end else if (sum < SatLo) begin
      norm_res.value     = SatLo[VW-1:0];
      norm_res.saturated = 1'b1;
    end else begin
      norm_res.value = sum[VW-1:0];
    end
  end

  always_comb begin
    exec_res = '0;
    unique case (in_q.command)
      smcn_pkg::CMD_TRACK: begin
        if (ok) begin
          exec_res.value   = VW'(xc);
          exec_res.run_max = new_max;
          exec_res.run_min = new_min;
        end
      end
      smcn_pkg::CMD_COMMIT, smcn_pkg::CMD_ABORT: begin
        if (ok) begin
          exec_res.run_max = smcn_pkg::SAMPLE_MID;
          exec_res.run_min = smcn_pkg::SAMPLE_MID;
        end
      end
      smcn_pkg::CMD_NORMALIZE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      res_q <= exec_res;
    end else if (ctrl_i.fin) begin
      res_q <= norm_res;
    end
    if (ctrl_i.load) begin
      out_q <= res_q;
    end
  end

  assign stat_o.norm     = (in_q.command == smcn_pkg::CMD_NORMALIZE) && ok;
  assign stat_o.div_done = div_done;
  assign out_data_o      = out_q;

endmodule

[rtl/smcn_ctrl.sv]
// ----------------------------------------------------------------------------
// smcn_ctrl: calibrator sequencer
// Steps one item through execute (or multiply, divide, finish) and result load.
// ----------------------------------------------------------------------------
module smcn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  smcn_pkg::stat_t stat_i,
  output smcn_pkg::ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_START,
    ST_DIV,
    ST_FIN,
    ST_LOAD
  } state_e;

  state_e state_q;
  logic   in_ready_q, out_valid_q;

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.latch     = in_valid_i && in_ready_q;
    ctrl_o.exec      = (state_q == ST_EXEC) && !stat_i.norm;
    ctrl_o.mul       = (state_q == ST_EXEC) && stat_i.norm;
    ctrl_o.div_start = (state_q == ST_START);
    ctrl_o.fin       = (state_q == ST_FIN);
    ctrl_o.load      = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl_o.latch) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_EXEC;
          end
        end
        ST_EXEC:  state_q <= stat_i.norm ? ST_START : ST_LOAD;
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (stat_i.div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN:   state_q <= ST_LOAD;
        ST_LOAD: begin
          if (ctrl_o.load) begin
            in_ready_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/sensor_min_max_calibrate_normalize_unit.sv]
// ----------------------------------------------------------------------------
// sensor_min_max_calibrate_normalize_unit: six-channel min/max calibrator
// Tracks running extremes per channel, commits them, normalizes samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid_i/in_ready_o) carry a command, a channel and a sample.
//   Track conditions the sample and widens that channel's running extremes;
//   commit copies all running extremes into the stored calibration; abort
//   restarts them at mid scale; normalize maps the sample from the stored
//   range onto out_lower..out_upper. Every input beat yields one output beat.
//   Configuration writes (cfg_we_i) take effect at once; write only when idle.
// Sequence:
//   Track, commit and abort: item register, result register, output register.
//   Normalize: item register, product register, then the radix-2 divider
//   that produces one quotient bit per cycle, then result and output register.
//   One item is in flight; the next is accepted the cycle after the result
//   enters the output register, even while that result waits for the sink.
// Reset: running extremes return to mid scale, stored range to full scale,
//   registers to their defaults; no output beat is pending.
// Stall: a held output beat keeps the finished next result waiting in the
//   datapath and blocks further input until the output register drains.
// ----------------------------------------------------------------------------
module sensor_min_max_calibrate_normalize_unit #(
  parameter int unsigned CHANNELS = smcn_pkg::DEFAULT_CHANNELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smcn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smcn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  smcn_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output smcn_pkg::out_t                  out_data_o
);

  // Command and status between sequencer and datapath
  smcn_pkg::ctrl_t ctrl;
  smcn_pkg::stat_t stat;

  // Sequencer: owns the handshakes and steps each item
  smcn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Datapath: registers, extremes, multiply/divide and output payload
  smcn_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  // Hold off input while an item is being worked on
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // Running extremes never cross
  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.run_max >= out_data_o.run_min)
    else $error("result shows running max below running min");

  // A zero span result is never also flagged as clipped
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_span |-> !out_data_o.saturated)
    else $error("zero span and saturated both set");

endmodule
